// ----- sv/mission_mode_supervisor_unit_defines.svh -----
// Assertion macros shared by the mission-mode supervisor RTL.
`ifndef MISSION_MODE_SUPERVISOR_UNIT_DEFINES_SVH
`define MISSION_MODE_SUPERVISOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mms_pkg.sv -----
// Types and constants of the mission-mode supervisor.
`timescale 1ns / 1ps

package mms_pkg;

    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int LEN_W   = 11;
    localparam int SEQ_N   = 6;
    localparam int CNT_W   = 3;

    typedef enum logic [3:0] {
        MODE_UNKNOWN  = 4'd0,
        MODE_WAIT     = 4'd1,
        MODE_AIR      = 4'd2,
        MODE_SEARCH   = 4'd3,
        MODE_CIRCLE   = 4'd4,
        MODE_GOTO     = 4'd5,
        MODE_RTL      = 4'd6,
        MODE_BATTERY  = 4'd7,
        MODE_COMMS    = 4'd8,
        MODE_LAND     = 4'd9,
        MODE_SHUTDOWN = 4'd10
    } mode_t;

    typedef enum logic [3:0] {
        ACT_RTL     = 4'd0,
        ACT_CLEAR   = 4'd1,
        ACT_AUTO    = 4'd2,
        ACT_CIRCLE  = 4'd3,
        ACT_LAND    = 4'd4,
        ACT_GOTO    = 4'd5,
        ACT_SEARCH  = 4'd6,
        ACT_REQUEST = 4'd7,
        ACT_DONE    = 4'd8
    } action_t;

    typedef enum logic [2:0] {
        OP_START      = 3'd0,
        OP_COMMAND    = 3'd1,
        OP_NEW_SEARCH = 3'd2,
        OP_REACHED    = 3'd3,
        OP_TICK       = 3'd4,
        OP_FAULT      = 3'd5
    } op_t;

    localparam logic [2:0] CMD_CIRCLE = 3'd1;
    localparam logic [2:0] CMD_RTL    = 3'd2;
    localparam logic [2:0] CMD_GOTO   = 3'd3;

    // Bit 0 battery low up to bit 4 circle command.
    typedef struct packed {
        logic circle;
        logic goto_cmd;
        logic rtl;
        logic comms;
        logic battery;
    } flags_t;

    typedef struct packed {
        action_t act;
        mode_t   mode;
    } entry_t;

endpackage

// ----- sv/mission_mode_supervisor_unit.sv -----
// Top level of the mission-mode supervisor: event decode, mode decision, action sequencer.
`timescale 1ns / 1ps
`include "mission_mode_supervisor_unit_defines.svh"

// Channel  Dir  Payload                                          Handshake
// s_*      in   tuser: operation; tdata: event fields             tvalid/tready
// m_*      out  tuser: action; tdata: goto, size, mode; tlast     tvalid/tready
//
// An event request is held in the input register, then is decoded,
// the mode decided and all of its actions loaded into a six-deep sequencer in
// one step. Results leave one per cycle while m_tready is high, at most six
// per event, from the sequencer shift register.
// A new event loads in the cycle the last action of the previous one is taken.
// Reset clears the mode, flags, goto position, search progress and handshakes.

module mission_mode_supervisor_unit
    import mms_pkg::*;
#(
    parameter int MAX_WAYPOINTS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] operation
    input  logic [7:0]  s_tuser,
    // [2:0] command_code, [33:3] target_lat, [65:34] target_lon,
    // [76:66] search_size, [87:77] reached_index, [88] battery_low,
    // [89] link_lost, [95:90] zero
    input  logic [95:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] action
    output logic [7:0]  m_tuser,
    // [30:0] goto_lat_out, [62:31] goto_lon_out, [73:63] search_size_out,
    // [77:74] mode_now, [79:78] zero
    output logic [79:0] m_tdata,
    output logic        m_tlast
);

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic                    in_valid_reg;
    logic [2:0]              in_op_reg;
    logic [2:0]              in_cmd_reg;
    logic signed [LAT_W-1:0] in_lat_reg;
    logic signed [LON_W-1:0] in_lon_reg;
    logic [LEN_W-1:0]        in_len_reg;
    logic [LEN_W-1:0]        in_idx_reg;
    logic                    in_batt_reg;
    logic                    in_link_reg;

    // ---------------------------------------------------------------
    // Supervisor state
    // ---------------------------------------------------------------
    mode_t                   mode_reg,      mode_next;
    flags_t                  flags_reg,     flags_next;
    logic signed [LAT_W-1:0] goto_lat_reg,  goto_lat_next;
    logic signed [LON_W-1:0] goto_lon_reg,  goto_lon_next;
    logic                    present_reg,   present_next;
    logic [LEN_W-1:0]        total_reg,     total_next;
    logic [LEN_W-1:0]        done_reg,      done_next;

    // ---------------------------------------------------------------
    // Action sequencer; entry 0 drives the output
    // ---------------------------------------------------------------
    entry_t                  seq_reg [SEQ_N];
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [LAT_W-1:0] out_lat_reg;
    logic signed [LON_W-1:0] out_lon_reg;
    logic [LEN_W-1:0]        out_size_reg;

    logic                    out_take;
    logic                    load;

    // Decode results
    op_t                     op;
    logic                    decide_en;
    logic                    start_req;
    logic                    done_prefix;
    logic                    tick_req;
    mode_t                   target;
    logic                    change_ok;
    logic [CNT_W-1:0]        prefix_n;
    logic [CNT_W-1:0]        body_n;
    entry_t                  entries [SEQ_N];
    logic [CNT_W-1:0]        n_total;
    logic [LEN_W-1:0]        len_sat;

    // Guards on leaving the current mode.
    function automatic logic guard_ok(mode_t cur, mode_t nxt, flags_t f);
        logic ok;
        ok = 1'b1;
        unique case (cur)
            MODE_LAND:     ok = (nxt == MODE_SHUTDOWN);
            MODE_SHUTDOWN: ok = (nxt == MODE_WAIT);
            MODE_BATTERY:  ok = (nxt == MODE_LAND);
            MODE_COMMS:    if (f.comms)    ok = (nxt == MODE_BATTERY) || (nxt == MODE_LAND);
            MODE_CIRCLE:   if (f.circle)   ok = (nxt == MODE_BATTERY);
            MODE_GOTO:     if (f.goto_cmd) ok = (nxt == MODE_BATTERY) || (nxt == MODE_COMMS);
            MODE_RTL:      if (f.rtl)      ok = (nxt == MODE_LAND);
            default:       ok = 1'b1;
        endcase
        return ok && (nxt != cur);
    endfunction

    // Number of actions on entering a mode.
    function automatic logic [CNT_W-1:0] seq_len(mode_t m);
        logic [CNT_W-1:0] len;
        unique case (m)
            MODE_SEARCH: len = CNT_W'(3);
            MODE_GOTO:   len = CNT_W'(4);
            MODE_AIR, MODE_CIRCLE, MODE_RTL, MODE_BATTERY, MODE_COMMS, MODE_LAND:
                         len = CNT_W'(5);
            default:     len = CNT_W'(4);
        endcase
        return len;
    endfunction

    // Action at position k of the entry sequence of a mode.
    function automatic action_t seq_act(mode_t m, logic [CNT_W-1:0] k);
        action_t a;
        a = k[0] ? ACT_CLEAR : ACT_RTL;
        unique case (m)
            MODE_SEARCH: a = (k == CNT_W'(0)) ? ACT_SEARCH : ACT_AUTO;
            MODE_GOTO:
            begin
                if (k == CNT_W'(2))
                begin
                    a = ACT_GOTO;
                end
                else if (k == CNT_W'(3))
                begin
                    a = ACT_AUTO;
                end
            end
            MODE_AIR:    if (k == CNT_W'(4)) a = ACT_REQUEST;
            MODE_CIRCLE: if (k == CNT_W'(4)) a = ACT_CIRCLE;
            MODE_LAND:   if (k == CNT_W'(4)) a = ACT_LAND;
            default:     if (k == CNT_W'(4)) a = ACT_RTL;
        endcase
        return a;
    endfunction

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign out_take = m_tvalid && m_tready;
    // Load when the sequencer is empty or hands over its last action now.
    assign load     = in_valid_reg &&
                      ((cnt_reg == '0) || (out_take && (cnt_reg == CNT_W'(1))));
    assign s_tready = !in_valid_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Hold the request fields until the event is processed.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser[2:0];
            in_cmd_reg  <= s_tdata[2:0];
            in_lat_reg  <= s_tdata[33:3];
            in_lon_reg  <= s_tdata[65:34];
            in_len_reg  <= s_tdata[76:66];
            in_idx_reg  <= s_tdata[87:77];
            in_batt_reg <= s_tdata[88];
            in_link_reg <= s_tdata[89];
        end
    end

    // ---------------------------------------------------------------
    // Event decode: update flags, goto and search progress
    // ---------------------------------------------------------------
    assign op = op_t'(in_op_reg);

    always_comb
    begin
        flags_next    = flags_reg;
        goto_lat_next = goto_lat_reg;
        goto_lon_next = goto_lon_reg;
        present_next  = present_reg;
        total_next    = total_reg;
        done_next     = done_reg;
        decide_en     = 1'b0;
        start_req     = 1'b0;
        done_prefix   = 1'b0;
        tick_req      = 1'b0;
        len_sat       = in_len_reg;
        // Clamp an oversized search to the waypoint limit.
        if (32'(in_len_reg) > 32'(MAX_WAYPOINTS))
        begin
            len_sat = LEN_W'(MAX_WAYPOINTS);
        end
        unique case (op)
            OP_START:
            begin
                start_req = 1'b1;
            end
            OP_COMMAND:
            begin
                flags_next.circle   = 1'b0;
                flags_next.goto_cmd = 1'b0;
                flags_next.rtl      = 1'b0;
                if (in_cmd_reg == CMD_CIRCLE)
                begin
                    flags_next.circle = 1'b1;
                end
                else if (in_cmd_reg == CMD_RTL)
                begin
                    flags_next.rtl = 1'b1;
                end
                else if (in_cmd_reg == CMD_GOTO)
                begin
                    flags_next.goto_cmd = 1'b1;
                    goto_lat_next       = in_lat_reg;
                    goto_lon_next       = in_lon_reg;
                end
                decide_en = 1'b1;
            end
            OP_NEW_SEARCH:
            begin
                present_next = 1'b1;
                total_next   = len_sat;
                done_next    = '0;
                decide_en    = 1'b1;
            end
            OP_REACHED:
            begin
                // Ignore a waypoint while not searching.
                if (mode_reg == MODE_SEARCH)
                begin
                    if (in_idx_reg == total_reg)
                    begin
                        done_prefix  = 1'b1;
                        present_next = 1'b0;
                        total_next   = '0;
                        done_next    = '0;
                        decide_en    = 1'b1;
                    end
                    else
                    begin
                        done_next = in_idx_reg;
                    end
                end
            end
            OP_TICK:
            begin
                tick_req = (mode_reg == MODE_AIR);
            end
            OP_FAULT:
            begin
                flags_next.battery = in_batt_reg;
                flags_next.comms   = in_link_reg;
                decide_en          = 1'b1;
            end
            default:
            begin
                decide_en = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Mode decision by fixed priority, then guards
    // ---------------------------------------------------------------
    always_comb
    begin
        target = MODE_AIR;
        priority if (start_req)
        begin
            target = MODE_WAIT;
        end
        else if (flags_next.battery)
        begin
            target = MODE_BATTERY;
        end
        else if (flags_next.comms)
        begin
            target = MODE_COMMS;
        end
        else if (flags_next.circle)
        begin
            target = MODE_CIRCLE;
        end
        else if (flags_next.goto_cmd)
        begin
            target = MODE_GOTO;
        end
        else if (flags_next.rtl)
        begin
            target = MODE_RTL;
        end
        else if (present_next && (done_next < total_next))
        begin
            target = MODE_SEARCH;
        end
        else
        begin
            target = MODE_AIR;
        end
        change_ok = (start_req || decide_en) && guard_ok(mode_reg, target, flags_next);
        mode_next = change_ok ? target : mode_reg;
    end

    // ---------------------------------------------------------------
    // Build the action list of this event
    // ---------------------------------------------------------------
    always_comb
    begin
        logic [CNT_W-1:0] k;
        prefix_n = (done_prefix || tick_req) ? CNT_W'(1) : CNT_W'(0);
        body_n   = change_ok ? seq_len(target) : CNT_W'(0);
        n_total  = prefix_n + body_n;
        for (int i = 0; i < SEQ_N; i++)
        begin
            k = CNT_W'(i) - prefix_n;
            entries[i].act  = ACT_RTL;
            entries[i].mode = mode_reg;
            if ((CNT_W'(i) < prefix_n))
            begin
                entries[i].act = done_prefix ? ACT_DONE : ACT_REQUEST;
            end
            else if (k < body_n)
            begin
                entries[i].act  = seq_act(target, k);
                entries[i].mode = target;
            end
        end
    end

    // ---------------------------------------------------------------
    // State and sequencer registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_UNKNOWN;
            flags_reg    <= '0;
            goto_lat_reg <= '0;
            goto_lon_reg <= '0;
            present_reg  <= 1'b0;
            total_reg    <= '0;
            done_reg     <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (load)
            begin
                mode_reg     <= mode_next;
                flags_reg    <= flags_next;
                goto_lat_reg <= goto_lat_next;
                goto_lon_reg <= goto_lon_next;
                present_reg  <= present_next;
                total_reg    <= total_next;
                done_reg     <= done_next;
                cnt_reg      <= n_total;
            end
            else if (out_take)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Load the new list, or advance one entry on each taken action.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < SEQ_N; i++)
            begin
                seq_reg[i] <= entries[i];
            end
            out_lat_reg  <= goto_lat_next;
            out_lon_reg  <= goto_lon_next;
            out_size_reg <= total_next;
        end
        else if (out_take)
        begin
            for (int i = 0; i < SEQ_N - 1; i++)
            begin
                seq_reg[i] <= seq_reg[i + 1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Output
    // ---------------------------------------------------------------
    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = (cnt_reg == CNT_W'(1));
    assign m_tuser  = {4'b0, seq_reg[0].act};
    assign m_tdata  = {2'b0,
                       seq_reg[0].mode,
                       (seq_reg[0].act == ACT_SEARCH) ? out_size_reg : LEN_W'(0),
                       (seq_reg[0].act == ACT_GOTO)   ? out_lon_reg  : LON_W'(0),
                       (seq_reg[0].act == ACT_GOTO)   ? out_lat_reg  : LAT_W'(0)};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `MMS_ASSERT_NOW(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(SEQ_N),
        "sequencer count above depth")
    `MMS_ASSERT_NOW(a_mode_range, clk, rst_n, 1'b1, mode_reg <= MODE_SHUTDOWN,
        "mode register out of range")
    `MMS_ASSERT_NEXT(a_req_held, clk, rst_n, in_valid_reg && !load, in_valid_reg,
        "pending request dropped before processing")
    `MMS_ASSERT_NEXT(a_cnt_step, clk, rst_n, out_take && (cnt_reg > CNT_W'(1)),
        cnt_reg == $past(cnt_reg) - CNT_W'(1), "sequencer did not advance by one")

endmodule
